// ----- src/pfdt_pkg.sv -----
// Shared types, codes and reset values for the pending flow deadline table.
package pfdt_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // request kinds
    localparam logic [1:0] KIND_PEND     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_EXPIRE   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUP_LATE  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BUDGET         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SERVICE_BUDGET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESERVED       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_CODE          = 3'd4;

    // configuration reset values
    localparam logic [63:0] RST_MAX_BUDGET         = 64'd1000000000;
    localparam logic [63:0] RST_MAX_SERVICE_BUDGET = 64'd1000000000;
    localparam logic [31:0] RST_MAX_RESERVED       = 32'hFFFF_FFFF;
    localparam logic [5:0]  RST_MAX_ENTRIES        = 6'd32;
    localparam logic [7:0]  RST_DROP_CODE          = 8'd0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] flow_id;
        logic [63:0] now_time;
        logic [63:0] budget;
        logic [31:0] reserve_bytes;
        logic [7:0]  decision;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] verdict;
        logic       cause;
        logic       last;
    } rsp_t;

    // contents one cell hands to its lower neighbor
    typedef struct packed {
        logic        valid;
        logic        kill;
        logic [63:0] flow;
        logic [63:0] deadline;
    } cell_t;

    // broadcast control to every cell of the row
    typedef struct packed {
        logic cmp;     // load kill and late flags from the compare
        logic expire;  // kill on deadline reached instead of flow match
        logic shift;   // close the lowest killed slot
        logic insert;  // write a new entry at the fill position
    } cell_ctl_t;

endpackage

// ----- src/pfdt_cell.sv -----
// One table cell: holds an entry, compares it, and shifts down to close a hole.
module pfdt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  pfdt_pkg::cell_ctl_t ctl,
    input  logic                ins,
    input  logic [63:0]         flow_id,
    input  logic [63:0]         now_time,
    input  logic [63:0]         deadline,
    input  pfdt_pkg::cell_t     up,
    output pfdt_pkg::cell_t     own,
    input  logic                hole_in,
    output logic                hole_out,
    output logic                multi,
    output logic                late
);

    logic        valid_reg, valid_next;
    logic        kill_reg, kill_next;
    logic        late_reg, late_next;
    logic [63:0] flow_reg, flow_next;
    logic [63:0] deadline_reg, deadline_next;
    logic        reached;
    logic        hole_le;

    assign reached  = now_time >= deadline_reg;
    assign hole_le  = hole_in | kill_reg;
    assign hole_out = hole_le;
    // a kill here with another one below means more than one remains
    assign multi    = kill_reg & hole_in;
    assign late     = late_reg;
    assign own      = '{valid: valid_reg, kill: kill_reg, flow: flow_reg,
                        deadline: deadline_reg};

    always_comb
    begin
        valid_next    = valid_reg;
        kill_next     = kill_reg;
        late_next     = late_reg;
        flow_next     = flow_reg;
        deadline_next = deadline_reg;
        if (ctl.cmp)
        begin
            kill_next = valid_reg & (ctl.expire ? reached : (flow_reg == flow_id));
            late_next = (now_time != '0) & reached;
        end
        if (ctl.shift && hole_le)
        begin
            valid_next    = up.valid;
            kill_next     = up.kill;
            flow_next     = up.flow;
            deadline_next = up.deadline;
        end
        if (ins)
        begin
            valid_next    = 1'b1;
            kill_next     = 1'b0;
            flow_next     = flow_id;
            deadline_next = deadline;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            kill_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            kill_reg  <= kill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        late_reg     <= late_next;
        flow_reg     <= flow_next;
        deadline_reg <= deadline_next;
    end

endmodule

// ----- src/pending_flow_deadline_table.sv -----
// Top level: request decode, sequencer, configuration and the row of table cells.
//
// Requests enter on req_valid/req_ready and carry a pend, complete or expire
// command; results leave on rsp_valid/rsp_ready from an output register.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data). The user
// must write it only while no request is in progress; this is not enforced.
// Entries sit packed in a row of cells, lowest first. Every cell compares its
// entry against the request in the compare state; removal shifts the cells
// above the lowest removed slot down by one, one removed entry per cycle while
// the output register is free. A pend, complete or unused-kind request gives
// one result from the execute state. An expire with nothing due gives no
// result; else each removed entry gives one timeout result, the last of them
// flagged as last.
// req_ready is high only between requests; a result waiting in the output
// register does not hold off the next request, but a stalled receiver holds
// the sequencer in place until the output register frees.
// Reset clears the table, the fill count and loads the default limits.
module pending_flow_deadline_table #(
    parameter int DEPTH = pfdt_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  pfdt_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output pfdt_pkg::rsp_t                   rsp,
    input  logic                             cfg_we,
    input  logic [pfdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfdt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC, S_DRAIN} state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    pfdt_pkg::rsp_t      rsp_reg, rsp_next;

    pfdt_pkg::req_t      req_reg;
    logic [63:0]         dl_reg;
    logic                arg_bad_reg;

    logic [63:0]         max_budget_reg;
    logic [63:0]         max_service_budget_reg;
    logic [31:0]         max_reserved_reg;
    logic [5:0]          max_entries_reg;
    logic [7:0]          drop_code_reg;

    pfdt_pkg::cell_ctl_t ctl;
    pfdt_pkg::cell_t     bus [DEPTH+1];
    logic [DEPTH:0]      hole_w;
    logic [DEPTH-1:0]    ins_vec;
    logic [DEPTH-1:0]    valid_vec;
    logic [DEPTH-1:0]    kill_vec;
    logic [DEPTH-1:0]    late_vec;
    logic [DEPTH-1:0]    multi_vec;

    logic                out_free;
    logic                kill_any;
    logic                late_any;
    logic                multi_any;
    logic                full;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign kill_any  = |kill_vec;
    assign late_any  = |(kill_vec & late_vec);
    assign multi_any = |multi_vec;
    assign full      = (CMPW'(count_reg) >= CMPW'(max_entries_reg)) ||
                       (CMPW'(count_reg) >= CMPW'(DEPTH));

    assign bus[DEPTH] = '0;
    assign hole_w[0]  = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign ins_vec[i]   = ctl.insert && (count_reg == CW'(i));
        assign valid_vec[i] = bus[i].valid;
        assign kill_vec[i]  = bus[i].kill;

        pfdt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .ins      (ins_vec[i]),
            .flow_id  (req_reg.flow_id),
            .now_time (req_reg.now_time),
            .deadline (dl_reg),
            .up       (bus[i+1]),
            .own      (bus[i]),
            .hole_in  (hole_w[i]),
            .hole_out (hole_w[i+1]),
            .multi    (multi_vec[i]),
            .late     (late_vec[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        rsp_next       = rsp_reg;
        ctl            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                ctl.cmp    = 1'b1;
                ctl.expire = (req_reg.kind == pfdt_pkg::KIND_EXPIRE);
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (req_reg.kind)
                    pfdt_pkg::KIND_PEND:
                    begin
                        if (out_free)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next = '{status: pfdt_pkg::ST_OK, verdict: 8'd0,
                                         cause: 1'b0, last: 1'b1};
                            if (arg_bad_reg)
                                rsp_next.status = pfdt_pkg::ST_INVALID;
                            else if (full)
                                rsp_next.status = pfdt_pkg::ST_FULL;
                            else if (kill_any)
                                rsp_next.status = pfdt_pkg::ST_DUP_LATE;
                            else
                            begin
                                ctl.insert = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = S_IDLE;
                        end
                    end
                    pfdt_pkg::KIND_COMPLETE:
                    begin
                        if (out_free)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next = '{status: pfdt_pkg::ST_NOT_FOUND, verdict: 8'd0,
                                         cause: 1'b0, last: 1'b1};
                            if (kill_any)
                            begin
                                ctl.shift  = 1'b1;
                                count_next = count_reg - CW'(1);
                                if (late_any)
                                    rsp_next.status = pfdt_pkg::ST_DUP_LATE;
                                else
                                begin
                                    rsp_next.status  = pfdt_pkg::ST_OK;
                                    rsp_next.verdict = req_reg.decision;
                                end
                            end
                            state_next = S_IDLE;
                        end
                    end
                    pfdt_pkg::KIND_EXPIRE:
                    begin
                        state_next = kill_any ? S_DRAIN : S_IDLE;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next = '{status: pfdt_pkg::ST_INVALID, verdict: 8'd0,
                                         cause: 1'b0, last: 1'b1};
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    ctl.shift      = 1'b1;
                    count_next     = count_reg - CW'(1);
                    rsp_valid_next = 1'b1;
                    rsp_next = '{status: pfdt_pkg::ST_OK, verdict: drop_code_reg,
                                 cause: 1'b1, last: !multi_any};
                    if (!multi_any)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // request capture; deadline sum and argument check are registered
    // during the compare cycle
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        if (state_reg == S_CMP)
        begin
            dl_reg      <= req_reg.now_time + req_reg.budget;
            arg_bad_reg <= (req_reg.flow_id == '0) || (req_reg.budget == '0) ||
                           (req_reg.budget > max_budget_reg) ||
                           (req_reg.budget > max_service_budget_reg) ||
                           (req_reg.reserve_bytes > max_reserved_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_budget_reg         <= pfdt_pkg::RST_MAX_BUDGET;
            max_service_budget_reg <= pfdt_pkg::RST_MAX_SERVICE_BUDGET;
            max_reserved_reg       <= pfdt_pkg::RST_MAX_RESERVED;
            max_entries_reg        <= pfdt_pkg::RST_MAX_ENTRIES;
            drop_code_reg          <= pfdt_pkg::RST_DROP_CODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfdt_pkg::CFG_MAX_BUDGET:         max_budget_reg         <= cfg_data;
                pfdt_pkg::CFG_MAX_SERVICE_BUDGET: max_service_budget_reg <= cfg_data;
                pfdt_pkg::CFG_MAX_RESERVED:       max_reserved_reg       <= cfg_data[31:0];
                pfdt_pkg::CFG_MAX_ENTRIES:        max_entries_reg        <= cfg_data[5:0];
                pfdt_pkg::CFG_DROP_CODE:          drop_code_reg          <= cfg_data[7:0];
                default:                          ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(valid_vec)))
        else $error("fill count differs from occupied cells");

    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("occupied cells not packed at the low end");

    a_drain_has_kill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> kill_any)
        else $error("draining with no expired entry left");

    a_unique_flow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC && req_reg.kind == pfdt_pkg::KIND_COMPLETE |->
        $onehot0(kill_vec))
        else $error("flow id held by more than one entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(DEPTH))
        else $error("fill count above table depth");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the pending flow deadline table.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TBL_DEPTH    = pfdt_pkg::DEPTH_DEFAULT;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          POOL_SIZE    = 24;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    // Behavioral copy of the table plus the queue of results still owed by the block.
    class flow_table_scoreboard;
        logic [63:0]    lim_budget;
        logic [63:0]    lim_service;
        logic [31:0]    lim_reserved;
        logic [5:0]     lim_entries;
        logic [7:0]     drop_verdict;
        bit             occupied[TBL_DEPTH];
        logic [63:0]    flow_of[TBL_DEPTH];
        logic [63:0]    deadline_of[TBL_DEPTH];
        int             live_count;
        pfdt_pkg::rsp_t awaited[$];
        int             errors;

        function new();
            lim_budget   = pfdt_pkg::RST_MAX_BUDGET;
            lim_service  = pfdt_pkg::RST_MAX_SERVICE_BUDGET;
            lim_reserved = pfdt_pkg::RST_MAX_RESERVED;
            lim_entries  = pfdt_pkg::RST_MAX_ENTRIES;
            drop_verdict = pfdt_pkg::RST_DROP_CODE;
            foreach (occupied[i])
                occupied[i] = 1'b0;
            live_count = 0;
            errors     = 0;
        endfunction

        function void set_limit(logic [pfdt_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                pfdt_pkg::CFG_MAX_BUDGET:         lim_budget   = val;
                pfdt_pkg::CFG_MAX_SERVICE_BUDGET: lim_service  = val;
                pfdt_pkg::CFG_MAX_RESERVED:       lim_reserved = val[31:0];
                pfdt_pkg::CFG_MAX_ENTRIES:        lim_entries  = val[5:0];
                pfdt_pkg::CFG_DROP_CODE:          drop_verdict = val[7:0];
                default: ;
            endcase
        endfunction

        function void owe_result(pfdt_pkg::rsp_t res);
            awaited.insert(awaited.size(), res);
        endfunction

        function void note_request(pfdt_pkg::req_t r);
            pfdt_pkg::rsp_t res;
            int             cap;
            int             slot;
            int             hits;
            int             i;
            res.status  = pfdt_pkg::ST_OK;
            res.verdict = 8'd0;
            res.cause   = 1'b0;
            res.last    = 1'b1;
            // capacity above the physical depth acts as the depth
            cap  = (int'(lim_entries) > TBL_DEPTH) ? TBL_DEPTH : int'(lim_entries);
            slot = -1;
            hits = 0;
            case (r.kind)
                pfdt_pkg::KIND_PEND:
                begin
                    if (r.flow_id == 64'd0 || r.budget == 64'd0 || r.budget > lim_budget ||
                        r.budget > lim_service || r.reserve_bytes > lim_reserved)
                        res.status = pfdt_pkg::ST_INVALID;
                    else if (live_count >= cap)
                        res.status = pfdt_pkg::ST_FULL;
                    else
                    begin
                        for (i = 0; i < TBL_DEPTH; i++)
                        begin
                            if (occupied[i] && flow_of[i] == r.flow_id)
                                res.status = pfdt_pkg::ST_DUP_LATE;
                            else if (!occupied[i] && slot < 0)
                                slot = i;
                        end
                        if (res.status == pfdt_pkg::ST_OK)
                        begin
                            occupied[slot]    = 1'b1;
                            flow_of[slot]     = r.flow_id;
                            deadline_of[slot] = r.now_time + r.budget;  // wraps at 64 bits
                            live_count++;
                        end
                    end
                    owe_result(res);
                end
                pfdt_pkg::KIND_COMPLETE:
                begin
                    res.status = pfdt_pkg::ST_NOT_FOUND;
                    for (i = 0; i < TBL_DEPTH; i++)
                        if (slot < 0 && occupied[i] && flow_of[i] == r.flow_id)
                            slot = i;
                    if (slot >= 0)
                    begin
                        occupied[slot] = 1'b0;
                        live_count--;
                        // zero time skips the deadline check
                        if (r.now_time != 64'd0 && r.now_time >= deadline_of[slot])
                            res.status = pfdt_pkg::ST_DUP_LATE;
                        else
                        begin
                            res.status  = pfdt_pkg::ST_OK;
                            res.verdict = r.decision;
                        end
                    end
                    owe_result(res);
                end
                pfdt_pkg::KIND_EXPIRE:
                begin
                    res.verdict = drop_verdict;
                    res.cause   = 1'b1;
                    res.last    = 1'b0;
                    for (i = 0; i < TBL_DEPTH; i++)
                    begin
                        if (occupied[i] && r.now_time >= deadline_of[i])
                        begin
                            occupied[i] = 1'b0;
                            live_count--;
                            hits++;
                            owe_result(res);
                        end
                    end
                    if (hits > 0)
                        awaited[$].last = 1'b1;
                end
                default:
                begin
                    res.status = pfdt_pkg::ST_INVALID;
                    owe_result(res);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(pfdt_pkg::rsp_t got);
            pfdt_pkg::rsp_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d verdict %0d",
                         $time, got.status, got.verdict);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("cause", 8'(want.cause), 8'(got.cause));
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            req_valid;
    logic                            req_ready;
    pfdt_pkg::req_t                  req;
    logic                            rsp_valid;
    logic                            rsp_ready;
    pfdt_pkg::rsp_t                  rsp;
    logic                            cfg_we;
    logic [pfdt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pfdt_pkg::CFG_DATA_W-1:0] cfg_data;

    bit                              gaps_on;
    bit                              hold_rsp;
    logic [63:0]                     sim_now;
    logic [63:0]                     flow_pool[POOL_SIZE];
    int                              quiet_cycles;
    flow_table_scoreboard            sb = new();

    pending_flow_deadline_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                sb.check_result(rsp);
        end
    end

    // watchdog: cycles with no request, result or register write
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
                rsp_ready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    function automatic pfdt_pkg::req_t flow_req(logic [1:0] kind, logic [63:0] flow,
                                                logic [63:0] at, logic [63:0] budget,
                                                logic [31:0] rsv, logic [7:0] dec);
        pfdt_pkg::req_t r;
        r.kind          = kind;
        r.flow_id       = flow;
        r.now_time      = at;
        r.budget        = budget;
        r.reserve_bytes = rsv;
        r.decision      = dec;
        return r;
    endfunction

    // mostly well-formed traffic on a small id pool, with corner values and noise mixed in
    function automatic pfdt_pkg::req_t random_request();
        pfdt_pkg::req_t r;
        int             pick;
        pick    = $urandom_range(0, 99);
        sim_now = sim_now + 64'($urandom_range(0, 800));
        r = flow_req(pfdt_pkg::KIND_PEND, flow_pool[$urandom_range(0, POOL_SIZE - 1)], sim_now,
                     64'($urandom_range(1, 6000)), 32'($urandom_range(0, 2000)), 8'($urandom));
        if (pick >= 45 && pick < 75)
            r.kind = pfdt_pkg::KIND_COMPLETE;
        else if (pick >= 75 && pick < 92)
            r.kind = pfdt_pkg::KIND_EXPIRE;
        else if (pick >= 92 && pick < 95)
            r.kind = KIND_UNUSED;
        else if (pick >= 95)
        begin
            r.kind          = 2'($urandom);
            r.flow_id       = {$urandom, $urandom};
            r.now_time      = {$urandom, $urandom};
            r.budget        = {$urandom, $urandom};
            r.reserve_bytes = $urandom;
        end
        case ($urandom_range(0, 19))
            0: r.now_time      = 64'd0;
            1: r.budget        = 64'd0;
            2: r.budget        = sb.lim_budget;
            3: r.budget        = sb.lim_budget + 64'd1;
            4: r.budget        = sb.lim_service;
            5: r.reserve_bytes = sb.lim_reserved;
            6: r.reserve_bytes = sb.lim_reserved + 32'd1;
            7: r.flow_id       = 64'd0;
            8: r.budget        = {$urandom, $urandom};
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_req(input pfdt_pkg::req_t r);
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            n = $urandom_range(1, 10);
            repeat (n) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_req(random_request());
    endtask

    // wait until every owed result is back, then let the block run idle before the next phase
    task automatic settle();
        req_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pfdt_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_limit(idx, val);
    endtask

    task automatic apply_limits(input logic [63:0] budget_lim, input logic [63:0] service_lim,
                                input logic [31:0] reserved_lim, input logic [5:0] entries_lim,
                                input logic [7:0] drop);
        write_reg(pfdt_pkg::CFG_MAX_BUDGET, budget_lim);
        write_reg(pfdt_pkg::CFG_MAX_SERVICE_BUDGET, service_lim);
        write_reg(pfdt_pkg::CFG_MAX_RESERVED, 64'(reserved_lim));
        write_reg(pfdt_pkg::CFG_MAX_ENTRIES, 64'(entries_lim));
        write_reg(pfdt_pkg::CFG_DROP_CODE, 64'(drop));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        req_valid <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        gaps_on   = 1'b0;
        hold_rsp  = 1'b0;
        sim_now   = 64'd5000;
        foreach (flow_pool[i])
            flow_pool[i] = {$urandom, $urandom};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass under reset limits
        send_req(flow_req(KIND_UNUSED, {$urandom, $urandom}, 64'd7, 64'd9, 32'd0, 8'h11));
        send_req(flow_req(pfdt_pkg::KIND_PEND, 64'd0, 64'd10, 64'd5, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_PEND, 64'd5, 64'd10, 64'd0, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_PEND, 64'd5, 64'd10,
                          pfdt_pkg::RST_MAX_BUDGET + 64'd1, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_PEND, ALL_ONES, 64'd0, pfdt_pkg::RST_MAX_BUDGET,
                          32'hFFFF_FFFF, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_PEND, ALL_ONES, 64'd0, pfdt_pkg::RST_MAX_BUDGET,
                          32'hFFFF_FFFF, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_PEND, 64'd1, 64'd100, 64'd1, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_COMPLETE, 64'd0, 64'd100, 64'd0, 32'd0, 8'h22));
        send_req(flow_req(pfdt_pkg::KIND_COMPLETE, 64'd2, 64'd100, 64'd0, 32'd0, 8'h33));
        send_req(flow_req(pfdt_pkg::KIND_COMPLETE, 64'd1, 64'd0, 64'd0, 32'd0, 8'hFF));
        send_req(flow_req(pfdt_pkg::KIND_PEND, 64'd1, 64'd100, 64'd50, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_COMPLETE, 64'd1, 64'd150, 64'd0, 32'd0, 8'h77));
        send_req(flow_req(pfdt_pkg::KIND_PEND, 64'h8000_0000_0000_0000, 64'd200, 64'd100,
                          32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_COMPLETE, 64'h8000_0000_0000_0000, 64'd299, 64'd0,
                          32'd0, 8'h00));
        // deadline wraps past the top of the time range
        send_req(flow_req(pfdt_pkg::KIND_PEND, 64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FF00,
                          64'h200, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_PEND, 64'd3, 64'd0, 64'd500, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_EXPIRE, 64'd0, 64'h50, 64'd0, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_EXPIRE, 64'd0, 64'h100, 64'd0, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_PEND, 64'd4, 64'd0, 64'd600, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_EXPIRE, 64'd0, ALL_ONES, 64'd0, 32'd0, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_COMPLETE, ALL_ONES, 64'd5, 64'd0, 32'd0, 8'h44));
        send_req(flow_req(pfdt_pkg::KIND_EXPIRE, 64'd0, 64'd0, 64'd0, 32'd0, 8'd0));
        settle();

        // wide-open limits: fill past depth under a stalled receiver, then flush all at once
        apply_limits(ALL_ONES, ALL_ONES, 32'hFFFF_FFFF, 6'd32, 8'hFF);
        gaps_on  = 1'b1;
        hold_rsp = 1'b1;
        repeat (TBL_DEPTH + 4)
            send_req(flow_req(pfdt_pkg::KIND_PEND, {$urandom, $urandom}, sim_now,
                              64'h4000_0000_0000_0000, $urandom, 8'd0));
        send_req(flow_req(pfdt_pkg::KIND_EXPIRE, 64'd0, ALL_ONES, 64'd0, 32'd0, 8'd0));
        run_random(100);
        settle();

        // tight limits and a four-entry table
        apply_limits(64'd5000, 64'd4000, 32'd1500, 6'd4, 8'h5A);
        gaps_on = 1'b0;
        run_random(40);
        gaps_on = 1'b1;
        run_random(70);
        settle();

        // everything at zero: no pend can pass
        apply_limits(64'd0, 64'd0, 32'd0, 6'd0, 8'd0);
        run_random(30);
        settle();

        // capacity register above the table depth
        apply_limits(pfdt_pkg::RST_MAX_BUDGET, 64'd4500, 32'hFFFF_FFFF, 6'd63, 8'hA5);
        run_random(90);
        settle();

        // closing stretch without idling
        apply_limits(64'd5500, ALL_ONES, 32'd1800, 6'd32, 8'h3C);
        gaps_on = 1'b0;
        run_random(80);
        settle();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
src/pfdt_pkg.sv
src/pfdt_cell.sv
src/pending_flow_deadline_table.sv
verif/tb.sv
